// ===== hdl/wsfr_pkg.sv =====
// ---------------------------------------------------------------------------
// wsfr_pkg: shared types and constants of the frame receiver
// Frame opcodes, result status codes, the parser phase type and the command
// that the header parser hands to the result stage through the queue.
// ---------------------------------------------------------------------------
package wsfr_pkg;

  // opcodes with a meaning of their own
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  // header length code that announces a 16-bit extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  // limit after reset
  localparam logic [31:0] MAX_BYTES_RESET = 32'd8388608;

  // command queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLOSE = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_HEAD0  = 3'd0,
    PH_HEAD1  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4
  } phase_e;

  // one result to build: raw byte and key byte are combined in the back stage
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       has_byte;
    logic       for_pong;
    logic       frame_end;
    logic       message_end;
    logic       is_binary;
    status_e    status;
  } cmd_t;

  // data frames are all but close, ping and pong
  function automatic logic is_data_op(input logic [3:0] op);
    is_data_op = (op != OP_CLOSE) && (op != OP_PING) && (op != OP_PONG);
  endfunction

endpackage

// ===== hdl/wsfr_front.sv =====
// ---------------------------------------------------------------------------
// wsfr_front: header parser and byte classifier
// Walks each frame header, checks lengths against the limit, tracks the mask
// key and message state, and issues one command per result item.
// ---------------------------------------------------------------------------
module wsfr_front import wsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_message_bytes_we_i,
  input  logic [31:0] max_message_bytes_i,
  input  logic        take_i,
  input  logic [7:0]  rx_byte_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o
);

  phase_e      phase_q, phase_d;
  logic        final_q, final_d;
  logic [3:0]  op_q, op_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;
  logic [3:0]  msg_op_q, msg_op_d;
  logic [31:0] msg_size_q, msg_size_d;
  logic        halted_q, halted_d;
  logic [31:0] limit_q;

  logic        act;
  logic        hd_long;
  logic [63:0] len_new;
  logic [32:0] size_sum;
  logic        over;
  logic        known;
  logic        mask_eff;
  logic        key_done;
  logic        start;
  logic [63:0] start_len;
  logic        empty;
  logic        data_last;
  logic [3:0]  msg_op_eff;
  logic [7:0]  key_sel;

  // shared decode of the current byte
  assign act       = take_i && !halted_q;
  assign hd_long   = (rx_byte_i[6:0] >= LEN_EXT16);
  assign len_new   = (phase_q == PH_HEAD1) ? {57'd0, rx_byte_i[6:0]}
                                           : {len_q[55:0], rx_byte_i};
  assign size_sum  = {1'b0, msg_size_q} + {1'b0, len_new[31:0]};
  assign over      = (|len_new[63:32]) || (size_sum > {1'b0, limit_q});
  assign known     = act && (((phase_q == PH_HEAD1) && !hd_long) ||
                             ((phase_q == PH_EXTLEN) && (cnt_q == 3'd0)));
  assign mask_eff  = (phase_q == PH_HEAD1) ? rx_byte_i[7] : mask_q;
  assign key_done  = act && (phase_q == PH_KEY) && (cnt_q == 3'd0);
  assign start     = (known && !over && !mask_eff) || key_done;
  assign start_len = (phase_q == PH_KEY) ? len_q : len_new;
  assign empty     = start && (start_len == 64'd0);
  assign data_last = (len_q == 64'd1);
  assign msg_op_eff = (is_data_op(op_q) && (op_q != OP_CONT)) ? op_q : msg_op_q;

  // key byte for the current payload position
  always_comb begin
    unique case (kidx_q)
      2'd0:    key_sel = key_q[31:24];
      2'd1:    key_sel = key_q[23:16];
      2'd2:    key_sel = key_q[15:8];
      default: key_sel = key_q[7:0];
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (act) begin
      unique case (phase_q)
        PH_HEAD0: phase_d = PH_HEAD1;
        PH_HEAD1, PH_EXTLEN: begin
          if ((phase_q == PH_HEAD1) && hd_long) begin
            phase_d = PH_EXTLEN;
          end else if (known && !over) begin
            if (mask_eff) begin
              phase_d = PH_KEY;
            end else begin
              phase_d = empty ? PH_HEAD0 : PH_DATA;
            end
          end
        end
        PH_KEY: begin
          if (key_done) begin
            phase_d = empty ? PH_HEAD0 : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_last) begin
            phase_d = PH_HEAD0;
          end
        end
        default: phase_d = PH_HEAD0;
      endcase
    end
  end

  // datapath state and command
  always_comb begin
    final_d     = final_q;
    op_d        = op_q;
    mask_d      = mask_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    kidx_d      = kidx_q;
    msg_op_d    = msg_op_q;
    msg_size_d  = msg_size_q;
    halted_d    = halted_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.status = ST_OK;

    if (act) begin
      unique case (phase_q)
        PH_HEAD0: begin
          final_d = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
        end
        PH_HEAD1: begin
          mask_d = rx_byte_i[7];
          if (hd_long) begin
            len_d = 64'd0;
            cnt_d = (rx_byte_i[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
          end else begin
            len_d = len_new;
          end
        end
        PH_EXTLEN: begin
          len_d = len_new;
          cnt_d = cnt_q - 3'd1;
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q - 3'd1;
        end
        PH_DATA: begin
          kidx_d = kidx_q + 2'd1;
          len_d  = len_q - 64'd1;
          if (op_q == OP_CLOSE) begin
            if (data_last) begin
              halted_d     = 1'b1;
              cmd_valid_o  = 1'b1;
              cmd_o.frame_end = 1'b1;
              cmd_o.status = ST_CLOSE;
            end
          end else if (op_q == OP_PING) begin
            cmd_valid_o     = 1'b1;
            cmd_o.raw_byte  = rx_byte_i;
            cmd_o.key_byte  = mask_q ? key_sel : 8'd0;
            cmd_o.has_byte  = 1'b1;
            cmd_o.for_pong  = 1'b1;
            cmd_o.frame_end = data_last;
          end else if (op_q != OP_PONG) begin
            msg_size_d      = msg_size_q + 32'd1;
            cmd_valid_o     = 1'b1;
            cmd_o.raw_byte  = rx_byte_i;
            cmd_o.key_byte  = mask_q ? key_sel : 8'd0;
            cmd_o.has_byte  = 1'b1;
            if (data_last) begin
              cmd_o.frame_end   = 1'b1;
              cmd_o.message_end = final_q;
              cmd_o.is_binary   = final_q && (msg_op_eff == OP_BINARY);
              if (final_q) begin
                msg_size_d = 32'd0;
                msg_op_d   = OP_CONT;
              end
            end
          end
        end
        default: ;
      endcase

      // length now known: check the limit, then go on to key or payload
      if (known) begin
        if (over) begin
          halted_d     = 1'b1;
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_OVER;
        end else begin
          msg_op_d = msg_op_eff;
          if (mask_eff) begin
            key_d = 32'd0;
            cnt_d = 3'd3;
          end
        end
      end

      // payload start, with the empty frame event
      if (start) begin
        kidx_d = 2'd0;
        if (empty) begin
          if (op_q == OP_CLOSE) begin
            halted_d        = 1'b1;
            cmd_valid_o     = 1'b1;
            cmd_o.frame_end = 1'b1;
            cmd_o.status    = ST_CLOSE;
          end else if (op_q == OP_PING) begin
            cmd_valid_o     = 1'b1;
            cmd_o.for_pong  = 1'b1;
            cmd_o.frame_end = 1'b1;
          end else if (op_q != OP_PONG) begin
            cmd_valid_o       = 1'b1;
            cmd_o.frame_end   = 1'b1;
            cmd_o.message_end = final_q;
            cmd_o.is_binary   = final_q && (msg_op_eff == OP_BINARY);
            if (final_q) begin
              msg_size_d = 32'd0;
              msg_op_d   = OP_CONT;
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEAD0;
      final_q    <= 1'b0;
      op_q       <= 4'd0;
      mask_q     <= 1'b0;
      len_q      <= 64'd0;
      cnt_q      <= 3'd0;
      key_q      <= 32'd0;
      kidx_q     <= 2'd0;
      msg_op_q   <= OP_CONT;
      msg_size_q <= 32'd0;
      halted_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      final_q    <= final_d;
      op_q       <= op_d;
      mask_q     <= mask_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      key_q      <= key_d;
      kidx_q     <= kidx_d;
      msg_op_q   <= msg_op_d;
      msg_size_q <= msg_size_d;
      halted_q   <= halted_d;
    end
  end

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MAX_BYTES_RESET;
    end else if (max_message_bytes_we_i) begin
      limit_q <= max_message_bytes_i;
    end
  end

endmodule

// ===== hdl/wsfr_queue.sv =====
// ---------------------------------------------------------------------------
// wsfr_queue: command queue between parser and result stage
// Small first-in first-out store of commands so each side stalls on its own.
// ---------------------------------------------------------------------------
module wsfr_queue import wsfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t           mem [QDepth];
  logic [QAw-1:0] wr_q, wr_d;
  logic [QAw-1:0] rd_q, rd_d;
  logic [QAw:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = push_i ? wr_q + QAw'(1) : wr_q;
    rd_d  = pop_i ? rd_q + QAw'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QAw+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/wsfr_back.sv =====
// ---------------------------------------------------------------------------
// wsfr_back: result stage
// Takes commands from the queue, unmasks the payload byte and holds the
// result item in the output register until the consumer takes it.
// ---------------------------------------------------------------------------
module wsfr_back import wsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       has_byte_o,
  output logic       for_pong_o,
  output logic       frame_end_o,
  output logic       message_end_o,
  output logic       is_binary_o,
  output logic [1:0] status_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       has_q, pong_q, fend_q, mend_q, bin_q;
  status_e    status_q;

  // load when the register is empty or its item is taken now
  assign pop_o = cmd_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q   <= cmd_i.raw_byte ^ cmd_i.key_byte;
      has_q    <= cmd_i.has_byte;
      pong_q   <= cmd_i.for_pong;
      fend_q   <= cmd_i.frame_end;
      mend_q   <= cmd_i.message_end;
      bin_q    <= cmd_i.is_binary;
      status_q <= cmd_i.status;
    end
  end

  assign out_valid_o    = valid_q;
  assign payload_byte_o = byte_q;
  assign has_byte_o     = has_q;
  assign for_pong_o     = pong_q;
  assign frame_end_o    = fend_q;
  assign message_end_o  = mend_q;
  assign is_binary_o    = bin_q;
  assign status_o       = status_q;

endmodule

// ===== hdl/websocket_frame_receiver_unit.sv =====
// A result item passes from the parser through the command queue into the output register.
// Throughput: one byte per cycle; the parser keeps up with the link byte rate.
// The 4-entry command queue lets the parser run on while a result waits downstream;
// input stalls only when that queue is full.
// Reset: parser goes to the first header byte, queue and output empty,
// limit back to 8 MiB; no clearing pass.
// ---------------------------------------------------------------------------
// websocket_frame_receiver_unit: frame receiver top level
// Header parser in front, command queue, result stage with output register.
// ---------------------------------------------------------------------------
module websocket_frame_receiver_unit import wsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_message_bytes_we_i,
  input  logic [31:0] max_message_bytes_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        has_byte_o,
  output logic        for_pong_o,
  output logic        frame_end_o,
  output logic        message_end_o,
  output logic        is_binary_o,
  output logic [1:0]  status_o
);

  logic q_full;
  logic take;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  cmd_t head;
  logic pop;

  // input item taken
  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  wsfr_front u_front (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .max_message_bytes_we_i (max_message_bytes_we_i),
    .max_message_bytes_i    (max_message_bytes_i),
    .take_i                 (take),
    .rx_byte_i              (rx_byte_i),
    .cmd_valid_o            (cmd_valid),
    .cmd_o                  (cmd)
  );

  wsfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_valid),
    .push_cmd_i (cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  wsfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (head_valid),
    .cmd_i          (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .has_byte_o     (has_byte_o),
    .for_pong_o     (for_pong_o),
    .frame_end_o    (frame_end_o),
    .message_end_o  (message_end_o),
    .is_binary_o    (is_binary_o),
    .status_o       (status_o)
  );

endmodule

// ===== test/tb_websocket_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_websocket_frame_receiver_unit: self-checking bench of the frame receiver
// Feeds the receive byte stream through the valid/stall port and checks every
// result item against a deframer model kept in the bench. A short table of
// hand-picked frames comes first, then random frames under several byte
// limits, with random gaps and stalls on both sides. The run ends on a close
// frame or an over-limit frame, since either one stops the block for good.
// ---------------------------------------------------------------------------
module tb_websocket_frame_receiver_unit;
  import wsfr_pkg::*;

  // opcodes and length codes the package does not name
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [31:0] LIMIT_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] LIMIT_NONE = 32'd0;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [7:0] payload;
    logic       has;
    logic       pong;
    logic       fend;
    logic       mend;
    logic       bin;
    status_e    status;
  } deframed_t;

  // one row of the directed stream: byte plus optional hand-typed result
  typedef struct packed {
    logic [7:0] rx;
    bit         typed;
    bit         got;
    deframed_t  want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        max_message_bytes_we_i = 1'b0;
  logic [31:0] max_message_bytes_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  payload_byte_o;
  logic        has_byte_o;
  logic        for_pong_o;
  logic        frame_end_o;
  logic        message_end_o;
  logic        is_binary_o;
  logic [1:0]  status_o;

  websocket_frame_receiver_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .max_message_bytes_we_i(max_message_bytes_we_i),
    .max_message_bytes_i   (max_message_bytes_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .payload_byte_o        (payload_byte_o),
    .has_byte_o            (has_byte_o),
    .for_pong_o            (for_pong_o),
    .frame_end_o           (frame_end_o),
    .message_end_o         (message_end_o),
    .is_binary_o           (is_binary_o),
    .status_o              (status_o)
  );

  always #6 clk_i = ~clk_i;

  // deframer model state
  phase_e      ps = PH_HEAD0;
  logic        hdr_fin = 1'b0;
  logic [3:0]  hdr_op = OP_CONT;
  logic        hdr_masked = 1'b0;
  logic [63:0] bytes_left = '0;
  int          hdr_left = 0;
  logic [31:0] key_word = '0;
  logic [1:0]  key_pos = '0;
  logic [3:0]  msg_kind = OP_CONT;
  logic [31:0] msg_bytes = '0;
  logic        stopped = 1'b0;
  logic [31:0] limit_bytes = MAX_BYTES_RESET;

  deframed_t deframed_q[$];
  dir_row_t  dir_tab[$];
  int        err_cnt = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        limit_writes = 0;
  bit        tx_calm = 1'b0;
  logic      rx_calm = 1'b0;
  logic      hold_tog = 1'b0;

  function automatic deframed_t ev(input logic [7:0] b, input logic has, input logic pong,
                                   input logic fend, input logic mend, input logic bin,
                                   input status_e st);
    ev = {b, has, pong, fend, mend, bin, st};
  endfunction

  function automatic logic [7:0] hdr0(input logic fin, input logic [3:0] op);
    hdr0 = {fin, 3'($urandom_range(0, 7)), op};
  endfunction

  function automatic logic [7:0] hdr1(input logic masked, input logic [6:0] code);
    hdr1 = {masked, code};
  endfunction

  // directed table helpers
  function automatic dir_row_t bare(input logic [7:0] b);
    bare = {b, 1'b0, 1'b0, deframed_t'('0)};
  endfunction

  function automatic dir_row_t with_out(input logic [7:0] b, input deframed_t r);
    with_out = {b, 1'b1, 1'b1, r};
  endfunction

  function automatic dir_row_t no_out(input logic [7:0] b);
    no_out = {b, 1'b1, 1'b0, deframed_t'('0)};
  endfunction

  // gap length: mostly short, a few long
  function automatic int pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) pause_len = $urandom_range(1, 3);
    else if (r < 97) pause_len = $urandom_range(4, 12);
    else pause_len = $urandom_range(20, 60);
  endfunction

  // any opcode but close, reserved ones now and then
  function automatic logic [3:0] pick_opcode();
    int unsigned r;
    logic [3:0] v;
    r = $urandom_range(0, 99);
    if (r < 22) pick_opcode = OP_CONT;
    else if (r < 42) pick_opcode = OP_TEXT;
    else if (r < 62) pick_opcode = OP_BINARY;
    else if (r < 85) pick_opcode = OP_PING;
    else if (r < 93) pick_opcode = OP_PONG;
    else begin
      v = 4'($urandom_range(0, 15));
      while (v == OP_CONT || v == OP_TEXT || v == OP_BINARY || v == OP_CLOSE ||
             v == OP_PING || v == OP_PONG)
        v = 4'($urandom_range(0, 15));
      pick_opcode = v;
    end
  endfunction

  function automatic longint unsigned pick_len(input longint unsigned room);
    int unsigned r;
    longint unsigned n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 64'($urandom_range(0, 3));
    else if (r < 90) n = 64'($urandom_range(4, 20));
    else if (r < 98) n = 64'($urandom_range(21, 140));
    else n = 64'($urandom_range(141, 300));
    pick_len = (n > room) ? room : n;
  endfunction

  // frame end of a data frame, message bookkeeping included
  task automatic end_data_frame(input logic [7:0] b, input logic has, output deframed_t r);
    logic fin_msg;
    fin_msg = hdr_fin;
    r = ev(has ? b : 8'h00, has, 1'b0, 1'b1, fin_msg, fin_msg && msg_kind == OP_BINARY, ST_OK);
    if (fin_msg) begin
      msg_bytes = '0;
      msg_kind = OP_CONT;
    end
  endtask

  // header done: go to payload, or finish an empty frame right away
  task automatic open_payload(output bit got, output deframed_t r);
    got = 1'b0;
    r = '0;
    key_pos = '0;
    if (bytes_left != 0) begin
      ps = PH_DATA;
      return;
    end
    ps = PH_HEAD0;
    case (hdr_op)
      OP_CLOSE: begin
        stopped = 1'b1;
        got = 1'b1;
        r = ev(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ST_CLOSE);
      end
      OP_PING: begin
        got = 1'b1;
        r = ev(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
      end
      OP_PONG: ;
      default: begin
        got = 1'b1;
        end_data_frame(8'h00, 1'b0, r);
      end
    endcase
  endtask

  // length known: limit check against frame and running message size
  task automatic check_frame_length(output bit got, output deframed_t r);
    got = 1'b0;
    r = '0;
    if (bytes_left > {32'd0, limit_bytes} ||
        {32'd0, msg_bytes} + bytes_left > {32'd0, limit_bytes}) begin
      stopped = 1'b1;
      got = 1'b1;
      r = ev(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OVER);
      return;
    end
    if (hdr_op != OP_CONT && hdr_op != OP_CLOSE && hdr_op != OP_PING && hdr_op != OP_PONG)
      msg_kind = hdr_op;
    if (hdr_masked) begin
      key_word = '0;
      hdr_left = 4;
      ps = PH_KEY;
    end else begin
      open_payload(got, r);
    end
  endtask

  // one received byte through the deframer
  task automatic deframe_byte(input logic [7:0] b, output bit got, output deframed_t r);
    logic [7:0] plain;
    logic last;
    got = 1'b0;
    r = '0;
    if (stopped) return;
    case (ps)
      PH_HEAD0: begin
        hdr_fin = b[7];
        hdr_op = b[3:0];
        ps = PH_HEAD1;
      end
      PH_HEAD1: begin
        hdr_masked = b[7];
        bytes_left = '0;
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          hdr_left = (b[6:0] == LEN_EXT16) ? 2 : 8;
          ps = PH_EXTLEN;
        end else begin
          bytes_left = 64'(b[6:0]);
          check_frame_length(got, r);
        end
      end
      PH_EXTLEN: begin
        bytes_left = {bytes_left[55:0], b};
        hdr_left--;
        if (hdr_left == 0) check_frame_length(got, r);
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_left--;
        if (hdr_left == 0) open_payload(got, r);
      end
      PH_DATA: begin
        plain = b ^ (hdr_masked ? key_word[8*(3-key_pos) +: 8] : 8'h00);
        key_pos++;
        bytes_left--;
        last = (bytes_left == 0);
        if (last) ps = PH_HEAD0;
        case (hdr_op)
          OP_CLOSE: begin
            if (last) begin
              stopped = 1'b1;
              got = 1'b1;
              r = ev(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ST_CLOSE);
            end
          end
          OP_PING: begin
            got = 1'b1;
            r = ev(plain, 1'b1, 1'b1, last, 1'b0, 1'b0, ST_OK);
          end
          OP_PONG: ;
          default: begin
            msg_bytes++;
            got = 1'b1;
            if (last) end_data_frame(plain, 1'b1, r);
            else r = ev(plain, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ST_OK);
          end
        endcase
      end
      default: ps = PH_HEAD0;
    endcase
  endtask

  // offer one byte, wait for the handshake, then record what it should cause
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit t_got = 1'b0, input deframed_t t_res = '0);
    int gap;
    bit got;
    deframed_t r;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    deframe_byte(b, got, r);
    if (typed) begin
      got = t_got;
      r = t_res;
    end
    if (got) deframed_q = {deframed_q, r};
  endtask

  // whole frame, length form picked at random among those that fit
  task automatic send_frame(input logic [3:0] op, input logic fin, input longint unsigned len,
                            input logic masked);
    int unsigned r;
    int form;
    logic [63:0] len_v;
    len_v = len;
    r = $urandom_range(0, 99);
    if (len < 126) form = (r < 70) ? 0 : (r < 88) ? 1 : 2;
    else if (len < 65536) form = (r < 80) ? 1 : 2;
    else form = 2;
    send_byte(hdr0(fin, op));
    send_byte(hdr1(masked, (form == 0) ? len_v[6:0] : (form == 1) ? LEN_EXT16 : LEN_EXT64));
    if (form == 1) begin
      send_byte(len_v[15:8]);
      send_byte(len_v[7:0]);
    end else if (form == 2) begin
      for (int k = 7; k >= 0; k--) send_byte(len_v[8*k +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom));
    for (longint unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    send_frame(pick_opcode(), $urandom_range(0, 9) < 7,
               pick_len(64'(limit_bytes) - 64'(msg_bytes)), $urandom_range(0, 9) < 6);
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_calm = ($urandom_range(0, 2) == 0);
        rx_calm <= ($urandom_range(0, 2) == 0);
      end
      send_random_frame();
    end
  endtask

  // new limit, written only once the block has gone quiet
  task automatic set_limit(input logic [31:0] v);
    if (msg_bytes > v) send_frame(OP_CONT, 1'b1, 0, 1'b0);
    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    max_message_bytes_we_i <= 1'b1;
    max_message_bytes_i <= v;
    limit_bytes = v;
    @(posedge clk_i);
    max_message_bytes_we_i <= 1'b0;
    limit_writes++;
  endtask

  // result side: random stall, long hold on request, compare each item
  initial begin
    int hold_left;
    logic seen_tog;
    deframed_t seen;
    deframed_t want;
    hold_left = 0;
    seen_tog = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        seen = {payload_byte_o, has_byte_o, for_pong_o, frame_end_o, message_end_o,
                is_binary_o, status_o};
        results_seen++;
        if (deframed_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result item: %p", seen);
        end else begin
          want = deframed_q.pop_front();
          if (seen !== want) begin
            err_cnt++;
            if (err_cnt <= 10) $display("mismatch: expected %p, got %p", want, seen);
          end
        end
      end
      if (hold_tog !== seen_tog) begin
        seen_tog = hold_tog;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      else if (!rx_calm && $urandom_range(0, 3) == 0) hold_left = pause_len();
      out_stall_i <= (hold_left > 0);
    end
  end

  // hard stop
  initial begin
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin
    bit close_end;
    longint unsigned room;
    longint unsigned n;
    logic [63:0] huge;
    int guard;

    dir_tab = '{
      // empty final text frame
      bare(hdr0(1'b1, OP_TEXT)),
      with_out(8'h00, ev(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, ST_OK)),
      // empty ping
      bare(hdr0(1'b1, OP_PING)),
      with_out(8'h00, ev(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK)),
      // empty pong gives nothing
      bare(hdr0(1'b1, OP_PONG)),
      no_out(8'h00),
      // masked binary, 16-bit length of one
      bare(hdr0(1'b1, OP_BINARY)),
      bare(hdr1(1'b1, LEN_EXT16)),
      bare(8'h00), bare(8'h01),
      bare(8'hFF), bare(8'h00), bare(8'hA5), bare(8'h5A),
      with_out(8'h00, ev(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, ST_OK)),
      // continuation-only message with a 64-bit length reads as text
      bare(hdr0(1'b1, OP_CONT)),
      bare(hdr1(1'b0, LEN_EXT64)),
      bare(8'h00), bare(8'h00), bare(8'h00), bare(8'h00),
      bare(8'h00), bare(8'h00), bare(8'h00), bare(8'h01),
      with_out(8'hC3, ev(8'hC3, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, ST_OK))
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].got, dir_tab[i].want);

    // reset limit
    run_random(230);

    // widest limit, with one long receiver hold while bytes keep coming
    set_limit(LIMIT_ALL_ONES);
    run_random(300);
    tx_calm = 1'b1;
    hold_tog <= ~hold_tog;
    repeat (6) send_random_frame();
    tx_calm = 1'b0;
    run_random(400);

    // zero limit: only empty frames pass
    set_limit(LIMIT_NONE);
    run_random(450);

    // tiny limit: messages hit the cap exactly
    set_limit(32'($urandom_range(1, 12)));
    run_random(600);

    set_limit(32'($urandom_range(13, 500)));
    run_random(740);

    // stop the block: close frame or over-limit length, then ignored bytes
    tx_calm = 1'b0;
    room = 64'(limit_bytes) - 64'(msg_bytes);
    close_end = 1'($urandom_range(0, 1));
    if (close_end) begin
      n = 64'($urandom_range(0, 5));
      if (n > room) n = room;
      send_frame(OP_CLOSE, 1'b1, n, 1'($urandom_range(0, 1)));
    end else begin
      huge = $urandom_range(0, 1) ? '1 : room + 1;
      send_byte(hdr0(1'($urandom_range(0, 1)), pick_opcode()));
      send_byte(hdr1(1'($urandom_range(0, 1)), LEN_EXT64));
      for (int k = 7; k > 0; k--) send_byte(huge[8*k +: 8]);
      send_byte(huge[7:0], 1'b1, 1'b1, ev(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OVER));
    end
    repeat (20) send_byte(8'($urandom), 1'b1, 1'b0);

    // drain
    in_valid_i <= 1'b0;
    guard = 0;
    while (deframed_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (deframed_q.size() != 0) begin
      $display("%0d result items never arrived", deframed_q.size());
      err_cnt += deframed_q.size();
    end

    $display("stream of %0d bytes, %0d result items compared, %0d limit writes incl. 0 and max",
             items_sent, results_seen, limit_writes);
    $display("block stopped by %s, %0d errors", close_end ? "a close frame" : "an oversize length",
             err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
